// ----- rtl/pfa_pkg.sv -----
// Shared types, constants and codes for the page-frame allocator.
package pfa_pkg;

    localparam int DEF_NUM_GROUPS      = 1024;
    localparam int DEF_PAGES_PER_GROUP = 64;

    localparam int PAGE_W     = 16;
    localparam int CMD_W      = 3;
    localparam int GRP_IN_W   = 10;
    localparam int STATUS_W   = 3;
    localparam int CFG_ADDR_W = 1;

    localparam logic [PAGE_W-1:0] END_MARK      = 16'hFFFF;
    localparam logic [PAGE_W-1:0] RESERVED_INIT = 16'd512;
    localparam logic [PAGE_W-1:0] LIMIT_INIT    = 16'd65518;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT        = 3'd0,
        CMD_ALLOC_PAGE  = 3'd1,
        CMD_FREE_PAGE   = 3'd2,
        CMD_ALLOC_GROUP = 3'd3,
        CMD_FREE_GROUP  = 3'd4
    } t_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_MEM     = 3'd1,
        ST_BAD_PAGE   = 3'd2,
        ST_NO_GROUP   = 3'd3,
        ST_NOT_LINKED = 3'd4
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RESERVED = 1'd0,
        CFG_LIMIT    = 1'd1
    } t_cfg_reg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_START,
        OP_INIT_STEP,
        OP_INIT_END,
        OP_DIV,
        OP_REM,
        OP_ALLOC_COMMIT,
        OP_FREE_COMMIT,
        OP_FAIL,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_GBASE,
        OP_W_RD,
        OP_W1_ADV,
        OP_W2_START,
        OP_W2_ADV,
        OP_UNLINK,
        OP_FG_BASE,
        OP_FG_PUSH,
        OP_FG_END,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_INIT_START,
        S_INIT_RUN,
        S_INIT_END,
        S_IDLE,
        S_PG_DIV,
        S_PG_REM,
        S_PG_COMMIT,
        S_FAIL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_GBASE,
        S_W1_TEST,
        S_W1_ADV,
        S_W2_TEST,
        S_W2_ADV,
        S_FG_BASE,
        S_FG_CHK,
        S_FG_PUSH,
        S_FG_END,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op     op;
        logic    sel_free;
        t_status code;
    } t_dp_ctl;

    typedef struct packed {
        logic head_ok;
        logic pg_ok;
        logic word_zero;
        logic scan_last;
        logic cur_ok;
        logic cur_in_g;
        logic steps_max;
        logic fg_ok;
        logic push_last;
        logic init_last;
        logic out_free;
    } t_dp_flags;

endpackage

// ----- rtl/pfa_if.sv -----
// Handshake channel interfaces for commands, results and register writes.
interface pfa_cmd_if import pfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [PAGE_W-1:0]   page_number;
    logic [GRP_IN_W-1:0] group_number;

    modport source (output valid, cmd, page_number, group_number, input ready);
    modport sink (input valid, cmd, page_number, group_number, output ready);
endinterface

interface pfa_res_if import pfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PAGE_W-1:0]   result_number;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   free_count;

    modport source (output valid, result_number, status, free_count, input ready);
    modport sink (input valid, result_number, status, free_count, output ready);
endinterface

interface pfa_cfg_if import pfa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [PAGE_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/pfa_ctrl.sv -----
// Command sequencer for the page-frame allocator.
module pfa_ctrl import pfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_flags        i_flags,
    output logic             o_ready,
    output t_dp_ctl          o_ctl
);

    t_state    r_state, n_state;
    t_cmd_code r_cmd, n_cmd;
    t_status   r_code, n_code;
    logic      r_init_cmd, n_init_cmd;
    logic      w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_ready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT_START;
            r_cmd      <= CMD_INIT;
            r_code     <= ST_OK;
            r_init_cmd <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= n_cmd;
            r_code     <= n_code;
            r_init_cmd <= n_init_cmd;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_code     = r_code;
        n_init_cmd = r_init_cmd;
        case (r_state)
            S_INIT_START: n_state = S_INIT_RUN;
            S_INIT_RUN: begin
                if (i_flags.init_last) n_state = S_INIT_END;
            end
            S_INIT_END: begin
                n_state    = r_init_cmd ? S_FIN : S_IDLE;
                n_init_cmd = 1'b0;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = t_cmd_code'(i_cmd);
                    case (t_cmd_code'(i_cmd))
                        CMD_INIT: begin
                            n_state    = S_INIT_START;
                            n_init_cmd = 1'b1;
                        end
                        CMD_ALLOC_PAGE:  n_state = S_PG_DIV;
                        CMD_FREE_PAGE:   n_state = S_PG_DIV;
                        CMD_ALLOC_GROUP: n_state = S_SCAN_RD;
                        CMD_FREE_GROUP:  n_state = S_FG_BASE;
                        default: begin
                            n_state = S_FAIL;
                            n_code  = ST_OK;
                        end
                    endcase
                end
            end
            S_PG_DIV: begin
                if (r_cmd == CMD_FREE_PAGE) begin
                    if (i_flags.pg_ok) begin
                        n_state = S_PG_REM;
                    end else begin
                        n_state = S_FAIL;
                        n_code  = ST_BAD_PAGE;
                    end
                end else if (i_flags.head_ok) begin
                    n_state = S_PG_REM;
                end else begin
                    n_state = S_FAIL;
                    n_code  = ST_NO_MEM;
                end
            end
            S_PG_REM:    n_state = S_PG_COMMIT;
            S_PG_COMMIT: n_state = S_FIN;
            S_FAIL:      n_state = S_FIN;
            S_SCAN_RD:   n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_flags.word_zero) begin
                    n_state = S_GBASE;
                end else if (i_flags.scan_last) begin
                    n_state = S_FAIL;
                    n_code  = ST_NO_GROUP;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_GBASE: n_state = S_W1_TEST;
            S_W1_TEST: begin
                if (i_flags.cur_ok && !i_flags.cur_in_g && !i_flags.steps_max) begin
                    n_state = S_W1_ADV;
                end else if (i_flags.cur_ok && i_flags.cur_in_g) begin
                    n_state = S_W2_TEST;
                end else begin
                    n_state = S_FAIL;
                    n_code  = ST_NOT_LINKED;
                end
            end
            S_W1_ADV: n_state = S_W1_TEST;
            S_W2_TEST: begin
                if (i_flags.cur_ok && i_flags.cur_in_g && !i_flags.steps_max) begin
                    n_state = S_W2_ADV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_W2_ADV:  n_state = S_W2_TEST;
            S_FG_BASE: n_state = S_FG_CHK;
            S_FG_CHK: begin
                if (i_flags.fg_ok) begin
                    n_state = S_FG_PUSH;
                end else begin
                    n_state = S_FAIL;
                    n_code  = ST_BAD_PAGE;
                end
            end
            S_FG_PUSH: begin
                if (i_flags.push_last) n_state = S_FG_END;
            end
            S_FG_END: n_state = S_FIN;
            S_FIN: begin
                if (i_flags.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.op       = OP_NONE;
        o_ctl.sel_free = (r_cmd == CMD_FREE_PAGE);
        o_ctl.code     = r_code;
        case (r_state)
            S_INIT_START: o_ctl.op = OP_INIT_START;
            S_INIT_RUN:   o_ctl.op = OP_INIT_STEP;
            S_INIT_END:   o_ctl.op = OP_INIT_END;
            S_IDLE:       o_ctl.op = w_accept ? OP_LOAD : OP_NONE;
            S_PG_DIV:     o_ctl.op = OP_DIV;
            S_PG_REM:     o_ctl.op = OP_REM;
            S_PG_COMMIT: begin
                o_ctl.op = (r_cmd == CMD_FREE_PAGE) ? OP_FREE_COMMIT : OP_ALLOC_COMMIT;
            end
            S_FAIL:     o_ctl.op = OP_FAIL;
            S_SCAN_RD:  o_ctl.op = OP_SCAN_RD;
            S_SCAN_CHK: o_ctl.op = i_flags.word_zero ? OP_NONE : OP_SCAN_NEXT;
            S_GBASE:    o_ctl.op = OP_GBASE;
            S_W1_TEST: begin
                if (i_flags.cur_ok && !i_flags.cur_in_g && !i_flags.steps_max) begin
                    o_ctl.op = OP_W_RD;
                end else if (i_flags.cur_ok && i_flags.cur_in_g) begin
                    o_ctl.op = OP_W2_START;
                end
            end
            S_W1_ADV: o_ctl.op = OP_W1_ADV;
            S_W2_TEST: begin
                if (i_flags.cur_ok && i_flags.cur_in_g && !i_flags.steps_max) begin
                    o_ctl.op = OP_W_RD;
                end else begin
                    o_ctl.op = OP_UNLINK;
                end
            end
            S_W2_ADV:  o_ctl.op = OP_W2_ADV;
            S_FG_BASE: o_ctl.op = OP_FG_BASE;
            S_FG_PUSH: o_ctl.op = OP_FG_PUSH;
            S_FG_END:  o_ctl.op = OP_FG_END;
            S_FIN:     o_ctl.op = i_flags.out_free ? OP_OUT : OP_NONE;
            default:   o_ctl.op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/pfa_datapath.sv -----
// Link memory, group bitmap memory, list registers and result register.
module pfa_datapath import pfa_pkg::*; #(
    parameter int NUM_GROUPS      = DEF_NUM_GROUPS,
    parameter int PAGES_PER_GROUP = DEF_PAGES_PER_GROUP
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PAGE_W-1:0]   i_page_number,
    input  logic [GRP_IN_W-1:0] i_group_number,
    input  t_dp_ctl             i_ctl,
    output t_dp_flags           o_flags,
    pfa_cfg_if.sink             i_cfg_ch,
    pfa_res_if.source           o_res_ch
);

    localparam int TOTAL = NUM_GROUPS * PAGES_PER_GROUP;
    localparam int AW    = $clog2(TOTAL);
    localparam int GW    = $clog2(NUM_GROUPS);
    localparam int BW    = $clog2(PAGES_PER_GROUP);
    localparam int SW    = $clog2(TOTAL + 1);
    localparam int XW    = PAGE_W + 1;
    localparam int DIV_S = PAGE_W + BW;
    localparam int MW    = PAGE_W + 2;
    localparam longint DIV_M_L =
        ((longint'(1) << DIV_S) + longint'(PAGES_PER_GROUP) - 1) / longint'(PAGES_PER_GROUP);
    localparam logic [MW-1:0] DIV_M   = MW'(DIV_M_L);
    localparam logic [XW-1:0] TOTAL_X = XW'(TOTAL);
    localparam logic [XW-1:0] PPG_X   = XW'(PAGES_PER_GROUP);

    function automatic logic f_ok(input logic [XW-1:0] p, input logic [XW-1:0] lo,
                                  input logic [XW-1:0] hi);
        return (p >= lo) && (p < hi);
    endfunction

    logic [PAGE_W-1:0]          r_link_mem [TOTAL];
    logic [PAGES_PER_GROUP-1:0] r_bm_mem [NUM_GROUPS];
    logic [PAGE_W-1:0]          r_link_rd;
    logic [PAGES_PER_GROUP-1:0] r_bm_rd;

    logic [PAGE_W-1:0] r_res, r_lim;
    logic [PAGE_W-1:0] r_head, n_head;
    logic [PAGE_W-1:0] r_count, n_count;
    logic [GW-1:0]     r_ptr, n_ptr;
    logic [GW-1:0]     r_scan_cnt, n_scan_cnt;
    logic [PAGE_W-1:0] r_pg, n_pg;
    logic [GRP_IN_W-1:0] r_grp, n_grp;
    logic [PAGE_W-1:0] r_x, n_x;
    logic [GW-1:0]     r_q, n_q;
    logic [BW-1:0]     r_rem, n_rem;
    logic [XW-1:0]     r_base, n_base;
    logic [PAGE_W-1:0] r_cur, n_cur;
    logic [PAGE_W-1:0] r_prev, n_prev;
    logic              r_has_prev, n_has_prev;
    logic [SW-1:0]     r_steps, n_steps;
    logic [AW-1:0]     r_idx, n_idx;
    logic [BW-1:0]     r_pidx, n_pidx;
    logic [PAGE_W-1:0] r_result, n_result;
    t_status           r_status, n_status;
    logic              r_ovalid;
    logic [PAGE_W-1:0] r_o_result, r_o_count;
    t_status           r_o_status;

    logic                       w_link_we, w_link_re;
    logic [AW-1:0]              w_link_waddr, w_link_raddr;
    logic [PAGE_W-1:0]          w_link_wdata;
    logic                       w_bm_we, w_bm_re;
    logic [GW-1:0]              w_bm_waddr, w_bm_raddr;
    logic [PAGES_PER_GROUP-1:0] w_bm_wdata;
    logic                       w_out_load;

    logic [XW-1:0]              w_lim, w_res, w_idx_x, w_cur_x;
    logic [PAGE_W-1:0]          w_div_x;
    logic [PAGE_W+MW-1:0]       w_prod;
    logic [PAGES_PER_GROUP-1:0] w_init_word, w_bit;
    logic [PAGE_W-1:0]          w_init_link;

    assign w_res   = XW'(r_res);
    assign w_lim   = (XW'(r_lim) < TOTAL_X) ? XW'(r_lim) : TOTAL_X;
    assign w_idx_x = XW'(r_idx);
    assign w_cur_x = XW'(r_cur);
    assign w_div_x = i_ctl.sel_free ? r_pg : r_head;
    assign w_prod  = (PAGE_W+MW)'(w_div_x) * (PAGE_W+MW)'(DIV_M);
    assign w_bit   = PAGES_PER_GROUP'(1) << r_rem;

    always_comb begin
        logic [XW-1:0] v_p;
        for (int j = 0; j < PAGES_PER_GROUP; j++) begin
            v_p            = r_base + XW'(j);
            w_init_word[j] = !f_ok(v_p, w_res, w_lim);
        end
    end

    always_comb begin
        w_init_link = PAGE_W'(w_idx_x + XW'(1));
        if ((r_res != '0) && (w_res <= TOTAL_X) && (w_idx_x == w_res - XW'(1))) begin
            w_init_link = END_MARK;
        end
        if ((w_lim != '0) && (w_idx_x == w_lim - XW'(1))) begin
            w_init_link = END_MARK;
        end
    end

    assign o_flags.head_ok   = f_ok(XW'(r_head), w_res, w_lim);
    assign o_flags.pg_ok     = f_ok(XW'(r_pg), w_res, w_lim);
    assign o_flags.word_zero = (r_bm_rd == '0);
    assign o_flags.scan_last = (r_scan_cnt == GW'(NUM_GROUPS - 1));
    assign o_flags.cur_ok    = (w_cur_x < w_lim);
    assign o_flags.cur_in_g  = (w_cur_x >= r_base) && (w_cur_x < r_base + PPG_X);
    assign o_flags.steps_max = (r_steps == SW'(TOTAL));
    assign o_flags.fg_ok     = (XW'(r_grp) < XW'(NUM_GROUPS)) && f_ok(r_base, w_res, w_lim)
                               && f_ok(r_base + PPG_X - XW'(1), w_res, w_lim);
    assign o_flags.push_last = (r_pidx == BW'(PAGES_PER_GROUP - 1));
    assign o_flags.init_last = (r_idx == AW'(TOTAL - 1));
    assign o_flags.out_free  = !r_ovalid || o_res_ch.ready;

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_scan_cnt = r_scan_cnt;
        n_pg       = r_pg;
        n_grp      = r_grp;
        n_x        = r_x;
        n_q        = r_q;
        n_rem      = r_rem;
        n_base     = r_base;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_has_prev = r_has_prev;
        n_steps    = r_steps;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_result   = r_result;
        n_status   = r_status;
        w_link_we    = 1'b0;
        w_link_waddr = '0;
        w_link_wdata = '0;
        w_link_re    = 1'b0;
        w_link_raddr = '0;
        w_bm_we      = 1'b0;
        w_bm_waddr   = '0;
        w_bm_wdata   = '0;
        w_bm_re      = 1'b0;
        w_bm_raddr   = '0;
        w_out_load   = 1'b0;
        case (i_ctl.op)
            OP_LOAD: begin
                n_pg       = i_page_number;
                n_grp      = i_group_number;
                n_scan_cnt = '0;
            end
            OP_INIT_START: begin
                n_idx  = '0;
                n_base = '0;
            end
            OP_INIT_STEP: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_idx;
                w_link_wdata = w_init_link;
                if (w_idx_x < XW'(NUM_GROUPS)) begin
                    w_bm_we    = 1'b1;
                    w_bm_waddr = GW'(r_idx);
                    w_bm_wdata = w_init_word;
                end
                n_idx  = r_idx + AW'(1);
                n_base = r_base + PPG_X;
            end
            OP_INIT_END: begin
                if (w_res < w_lim) begin
                    n_head  = r_res;
                    n_count = PAGE_W'(w_lim - w_res);
                end else begin
                    n_head  = END_MARK;
                    n_count = '0;
                end
                n_result = END_MARK;
                n_status = ST_OK;
            end
            OP_DIV: begin
                n_x = w_div_x;
                n_q = GW'(w_prod >> DIV_S);
                if (!i_ctl.sel_free) begin
                    w_link_re    = 1'b1;
                    w_link_raddr = AW'(r_head);
                end
            end
            OP_REM: begin
                n_rem      = BW'(XW'(r_x) - XW'(r_q) * PPG_X);
                w_bm_re    = 1'b1;
                w_bm_raddr = r_q;
            end
            OP_ALLOC_COMMIT: begin
                n_head     = r_link_rd;
                n_count    = r_count - PAGE_W'(1);
                w_bm_we    = 1'b1;
                w_bm_waddr = r_q;
                w_bm_wdata = r_bm_rd | w_bit;
                n_result   = r_x;
                n_status   = ST_OK;
            end
            OP_FREE_COMMIT: begin
                w_link_we    = 1'b1;
                w_link_waddr = AW'(r_x);
                w_link_wdata = r_head;
                n_head       = r_x;
                n_count      = r_count + PAGE_W'(1);
                w_bm_we      = 1'b1;
                w_bm_waddr   = r_q;
                w_bm_wdata   = r_bm_rd & ~w_bit;
                n_result     = END_MARK;
                n_status     = ST_OK;
            end
            OP_FAIL: begin
                n_result = END_MARK;
                n_status = i_ctl.code;
            end
            OP_SCAN_RD: begin
                w_bm_re    = 1'b1;
                w_bm_raddr = r_ptr;
            end
            OP_SCAN_NEXT: begin
                n_ptr      = (r_ptr == GW'(NUM_GROUPS - 1)) ? '0 : r_ptr + GW'(1);
                n_scan_cnt = r_scan_cnt + GW'(1);
            end
            OP_GBASE: begin
                n_base     = XW'(r_ptr) * PPG_X;
                n_cur      = r_head;
                n_has_prev = 1'b0;
                n_steps    = '0;
            end
            OP_W_RD: begin
                w_link_re    = 1'b1;
                w_link_raddr = AW'(r_cur);
            end
            OP_W1_ADV: begin
                n_prev     = r_cur;
                n_has_prev = 1'b1;
                n_cur      = r_link_rd;
                n_steps    = r_steps + SW'(1);
            end
            OP_W2_START: n_steps = '0;
            OP_W2_ADV: begin
                n_cur   = r_link_rd;
                n_steps = r_steps + SW'(1);
            end
            OP_UNLINK: begin
                if (r_has_prev) begin
                    w_link_we    = 1'b1;
                    w_link_waddr = AW'(r_prev);
                    w_link_wdata = r_cur;
                end else begin
                    n_head = r_cur;
                end
                w_bm_we    = 1'b1;
                w_bm_waddr = r_ptr;
                w_bm_wdata = '1;
                n_count    = r_count - PAGE_W'(PAGES_PER_GROUP);
                n_result   = PAGE_W'(r_ptr);
                n_status   = ST_OK;
            end
            OP_FG_BASE: begin
                n_base = XW'(r_grp) * PPG_X;
                n_cur  = PAGE_W'(XW'(r_grp) * PPG_X);
                n_pidx = '0;
            end
            OP_FG_PUSH: begin
                w_link_we    = 1'b1;
                w_link_waddr = AW'(r_cur);
                w_link_wdata = r_head;
                n_head       = r_cur;
                n_cur        = r_cur + PAGE_W'(1);
                n_pidx       = r_pidx + BW'(1);
            end
            OP_FG_END: begin
                w_bm_we    = 1'b1;
                w_bm_waddr = GW'(r_grp);
                w_bm_wdata = '0;
                n_count    = r_count + PAGE_W'(PAGES_PER_GROUP);
                n_result   = END_MARK;
                n_status   = ST_OK;
            end
            OP_OUT:  w_out_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) r_link_mem[w_link_waddr] <= w_link_wdata;
        if (w_link_re) r_link_rd <= r_link_mem[w_link_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_bm_we) r_bm_mem[w_bm_waddr] <= w_bm_wdata;
        if (w_bm_re) r_bm_rd <= r_bm_mem[w_bm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= RESERVED_INIT;
            r_lim    <= LIMIT_INIT;
            r_ptr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_ch.valid && (t_cfg_reg'(i_cfg_ch.addr) == CFG_RESERVED)) begin
                r_res <= i_cfg_ch.data;
            end
            if (i_cfg_ch.valid && (t_cfg_reg'(i_cfg_ch.addr) == CFG_LIMIT)) begin
                r_lim <= i_cfg_ch.data;
            end
            r_ptr <= n_ptr;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_count    <= n_count;
        r_scan_cnt <= n_scan_cnt;
        r_pg       <= n_pg;
        r_grp      <= n_grp;
        r_x        <= n_x;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_base     <= n_base;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_has_prev <= n_has_prev;
        r_steps    <= n_steps;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_result   <= n_result;
        r_status   <= n_status;
        if (w_out_load) begin
            r_o_result <= r_result;
            r_o_status <= r_status;
            r_o_count  <= r_count;
        end
    end

    assign i_cfg_ch.ready         = 1'b1;
    assign o_res_ch.valid         = r_ovalid;
    assign o_res_ch.result_number = r_o_result;
    assign o_res_ch.status        = r_o_status;
    assign o_res_ch.free_count    = r_o_count;

endmodule

// ----- rtl/page_frame_allocator.sv -----
// Alloc page and free page each return one result beat; commands are taken one at a time.
// Alloc group scans the bitmap words, then walks the link memory to unlink the group found.
// Free group pushes each page of the group onto the free list; init rebuilds the whole list.
// One command is in flight at a time.
// After reset a clearing pass rebuilds the list with no command accepted; register writes
// are taken throughout.
module page_frame_allocator import pfa_pkg::*; #(
    parameter int NUM_GROUPS      = DEF_NUM_GROUPS,
    parameter int PAGES_PER_GROUP = DEF_PAGES_PER_GROUP
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfa_cmd_if.sink   i_cmd_ch,
    pfa_cfg_if.sink   i_cfg_ch,
    pfa_res_if.source o_res_ch
);

    t_dp_ctl   w_ctl;
    t_dp_flags w_flags;
    logic      w_ready;

    assign i_cmd_ch.ready = w_ready;

    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd_ch.valid),
        .i_cmd   (i_cmd_ch.cmd),
        .i_flags (w_flags),
        .o_ready (w_ready),
        .o_ctl   (w_ctl)
    );

    pfa_datapath #(
        .NUM_GROUPS      (NUM_GROUPS),
        .PAGES_PER_GROUP (PAGES_PER_GROUP)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_page_number  (i_cmd_ch.page_number),
        .i_group_number (i_cmd_ch.group_number),
        .i_ctl          (w_ctl),
        .o_flags        (w_flags),
        .i_cfg_ch       (i_cfg_ch),
        .o_res_ch       (o_res_ch)
    );

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_ch.valid && i_cmd_ch.ready) |=> !i_cmd_ch.ready)
        else $error("Command beat accepted while another command is in flight.");

    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_ch.ready)
        else $error("Command port ready during the clearing pass after reset.");

    a_result_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && (o_res_ch.result_number != END_MARK))
            |-> (o_res_ch.status == ST_OK))
        else $error("Allocated number returned with a failure status.");

endmodule
